/* design/pcn_pkg.sv */
`timescale 1ns / 1ps
package pcn_pkg;

   localparam logic [7:0] SLASH     = 8'h2F;
   localparam logic [7:0] BACKSLASH = 8'h5C;
   localparam logic [7:0] DOT       = 8'h2E;

   localparam logic [1:0] POS_START = 2'd0;
   localparam logic [1:0] POS_HELD  = 2'd1;
   localparam logic [1:0] POS_BODY  = 2'd2;
   localparam logic [1:0] POS_UNC   = 2'd3;

   localparam logic [1:0] PHASE_START = 2'd0;
   localparam logic [1:0] PHASE_DOT   = 2'd1;
   localparam logic [1:0] PHASE_TEXT  = 2'd2;

   localparam int MAX_RESULTS = 3;

   typedef struct packed {
      logic [1:0] pos;
      logic [7:0] held;
      logic [1:0] phase;
      logic       pend;
   } state_type;

   typedef struct packed {
      logic [1:0]                   count;
      logic [MAX_RESULTS-1:0][7:0] data;
      logic                         empty;
   } result_type;

endpackage

/* design/pcn_step.sv */
`timescale 1ns / 1ps
module pcn_step (
   input  pcn_pkg::state_type  state_i,
   input  logic [7:0]          byte_i,
   input  logic                final_i,
   output pcn_pkg::state_type  state_o,
   output pcn_pkg::result_type result_o
);

   typedef struct packed {
      pcn_pkg::state_type                   st;
      logic [1:0]                           n;
      logic [pcn_pkg::MAX_RESULTS-1:0][7:0] data;
   } work_type;

   function automatic work_type put(work_type w, logic [7:0] b);
      work_type r;
      r = w;
      r.data[r.n] = b;
      r.n = r.n + 2'd1;
      return r;
   endfunction

   function automatic work_type commit(work_type w, logic [7:0] b);
      work_type r;
      r = w;
      if (r.st.pos == pcn_pkg::POS_UNC) begin
         r = put(r, pcn_pkg::SLASH);
         r.st.pos = pcn_pkg::POS_BODY;
      end
      return put(r, b);
   endfunction

   function automatic work_type flush(work_type w);
      work_type r;
      r = w;
      if (r.st.pend) begin
         r.st.pend = 1'b0;
         r = commit(r, pcn_pkg::SLASH);
      end
      return r;
   endfunction

   function automatic work_type body(work_type w, logic [7:0] b, logic sep);
      work_type r;
      r = w;
      if (sep) begin
         if (r.st.phase == pcn_pkg::PHASE_DOT) begin
            r.st.phase = pcn_pkg::PHASE_START;
         end else if (r.st.phase != pcn_pkg::PHASE_START) begin
            r.st.pend  = 1'b1;
            r.st.phase = pcn_pkg::PHASE_START;
         end
      end else if (r.st.phase == pcn_pkg::PHASE_START) begin
         if (b == pcn_pkg::DOT) begin
            r.st.phase = pcn_pkg::PHASE_DOT;
         end else begin
            r = flush(r);
            r = commit(r, b);
            r.st.phase = pcn_pkg::PHASE_TEXT;
         end
      end else if (r.st.phase == pcn_pkg::PHASE_DOT) begin
         r = flush(r);
         r = commit(r, pcn_pkg::DOT);
         r = commit(r, b);
         r.st.phase = pcn_pkg::PHASE_TEXT;
      end else begin
         r = commit(r, b);
      end
      return r;
   endfunction

   logic     sep;
   work_type w;

   assign sep = (byte_i == pcn_pkg::SLASH) || (byte_i == pcn_pkg::BACKSLASH);

   always_comb begin
      w      = '0;
      w.st   = state_i;
      result_o = '0;
      unique case (state_i.pos)
         pcn_pkg::POS_START: begin
            if (sep) begin
               if (final_i) begin
                  w = put(w, pcn_pkg::SLASH);
               end else begin
                  w.st.held = byte_i;
                  w.st.pos  = pcn_pkg::POS_HELD;
               end
            end else begin
               w.st.pos = pcn_pkg::POS_BODY;
               w = body(w, byte_i, 1'b0);
            end
         end
         pcn_pkg::POS_HELD: begin
            if (sep) begin
               w = put(w, state_i.held);
               if (byte_i == pcn_pkg::SLASH) begin
                  w.st.pos = pcn_pkg::POS_UNC;
               end else begin
                  w = put(w, byte_i);
                  w.st.pos = pcn_pkg::POS_BODY;
               end
            end else begin
               w = put(w, pcn_pkg::SLASH);
               w.st.pos = pcn_pkg::POS_BODY;
               w = body(w, byte_i, 1'b0);
            end
         end
         default: begin
            w = body(w, byte_i, sep);
         end
      endcase
      if (final_i && (w.st.phase == pcn_pkg::PHASE_DOT)) begin
         w = flush(w);
         w = commit(w, pcn_pkg::DOT);
      end
      result_o.data  = w.data;
      result_o.count = w.n;
      if (final_i && (w.n == 2'd0)) begin
         result_o.count = 2'd1;
         result_o.empty = 1'b1;
         result_o.data  = '0;
      end
      state_o = final_i ? pcn_pkg::state_type'('0) : w.st;
   end

endmodule

/* design/path_component_normalizer_unit.sv */
`timescale 1ns / 1ps
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | req_path_byte, req_is_final
// rsp     | out       | rsp_valid/rsp_stall  | rsp_out_byte, rsp_out_last, rsp_out_empty
//
// One byte per cycle while neither side stalls: an input register feeds a single
// combinational step into a three-entry result register, drained one result per
// cycle while rsp_stall is low. A byte that yields two or three results holds the
// input until its last result is taken; bytes with zero or one result flow at one per cycle.
// Synchronous active-high reset clears the path state and the valid flags of both registers.
// rsp_stall backs up into req_stall only once the input register is full.
module path_component_normalizer_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_path_byte,
   input  logic       req_is_final,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last,
   output logic       rsp_out_empty
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                in_final_ff;
   pcn_pkg::state_type  state_ff, state_in, state_next;
   pcn_pkg::result_type res;
   logic [1:0]          rem_ff, rem_in;
   logic [1:0]          idx_ff, idx_in;
   logic [pcn_pkg::MAX_RESULTS-1:0][7:0] data_ff;
   logic                last_ff;
   logic                empty_ff;
   logic                move;
   logic                take;
   logic                accept;

   pcn_step u_step (
      .state_i  (state_ff),
      .byte_i   (in_byte_ff),
      .final_i  (in_final_ff),
      .state_o  (state_next),
      .result_o (res)
   );

   assign rsp_valid     = (rem_ff != 2'd0);
   assign take          = rsp_valid && !rsp_stall;
   assign move          = in_valid_ff && ((rem_ff == 2'd0) || ((rem_ff == 2'd1) && take));
   assign req_stall     = in_valid_ff && !move;
   assign accept        = req_valid && !req_stall;
   assign rsp_out_byte  = data_ff[idx_ff];
   assign rsp_out_last  = last_ff && (rem_ff == 2'd1);
   assign rsp_out_empty = empty_ff;

   always_comb begin
      in_valid_in = accept ? 1'b1 : (move ? 1'b0 : in_valid_ff);
      state_in    = move ? state_next : state_ff;
      rem_in      = rem_ff;
      idx_in      = idx_ff;
      if (move) begin
         rem_in = res.count;
         idx_in = 2'd0;
      end else if (take) begin
         rem_in = rem_ff - 2'd1;
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '0;
         rem_ff      <= 2'd0;
         idx_ff      <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
         rem_ff      <= rem_in;
         idx_ff      <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff  <= req_path_byte;
         in_final_ff <= req_is_final;
      end
      if (move) begin
         data_ff  <= res.data;
         last_ff  <= in_final_ff;
         empty_ff <= res.empty;
      end
   end

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_empty |-> rsp_out_last && (rsp_out_byte == 8'd0))
      else $error("empty transaction not marked last or carries data");

   a_multi_holds_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && (rem_ff > 2'd1) |-> req_stall)
      else $error("input moved while several results were pending");

   a_final_resets_state: assert property (@(posedge clock) disable iff (reset)
      move && in_final_ff |=> (state_ff == pcn_pkg::state_type'('0)))
      else $error("path state not cleared after final byte");

   a_final_yields_result: assert property (@(posedge clock) disable iff (reset)
      move && in_final_ff |=> rsp_valid)
      else $error("final byte produced no transaction");

endmodule
